/* rtl/complex_number_alu_assert.svh */
// Assertion macros for the complex number ALU.
// Used by files that assert; expects clk_i and rst_ni in scope.
`ifndef COMPLEX_NUMBER_ALU_ASSERT_SVH
`define COMPLEX_NUMBER_ALU_ASSERT_SVH
`ifndef SYNTHESIS
// property that holds at every edge outside reset
`define CNA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication
`define CNA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CNA_ASSERT(lbl, prop, msg)
`define CNA_ASSERT_IMPL(lbl, ante, cons, msg)
`define CNA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/cna_pkg.sv */
// Shared types and constants for the complex number ALU.
// No dependencies; imported by cna_step, complex_number_alu and tb_top.
`default_nettype none

package cna_pkg;

  // default operand format: signed Q16.16
  localparam int unsigned CNA_WIDTH     = 32;
  localparam int unsigned CNA_FRAC_BITS = 16;
  localparam int unsigned CNA_OP_W      = 3;

  typedef enum logic [CNA_OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4,
    OP_EQ  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // control that travels with a word down the pipeline
  typedef struct packed {
    op_e     op;
    logic    dz;      // divisor is zero
    logic    neg_re;  // sign of real numerator / product sum
    logic    neg_im;
    logic    ovf_re;  // quotient already known too large
    logic    ovf_im;
    logic    eq;      // equality result
    status_e st;      // status of the simple ops
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/cna_step.sv */
// One pipelined iteration: a restoring divide bit on both quotient lanes
// and, when enabled, one restoring square root digit. Uses cna_pkg.
`default_nettype none

module cna_step import cna_pkg::*; #(
  parameter int unsigned WIDTH   = CNA_WIDTH,
  parameter bit          DO_SQRT = 1'b1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  output logic                 vld_o,
  input  ctl_t                 ctl_i,
  output ctl_t                 ctl_o,
  input  logic [2*WIDTH-1:0]   pass_i,
  output logic [2*WIDTH-1:0]   pass_o,
  input  logic [2*WIDTH-1:0]   d_i,
  output logic [2*WIDTH-1:0]   d_o,
  input  logic [2*WIDTH-2:0]   r_re_i,
  output logic [2*WIDTH-2:0]   r_re_o,
  input  logic [WIDTH:0]       q_re_i,
  output logic [WIDTH:0]       q_re_o,
  input  logic [WIDTH:0]       lo_re_i,
  output logic [WIDTH:0]       lo_re_o,
  input  logic [2*WIDTH-2:0]   r_im_i,
  output logic [2*WIDTH-2:0]   r_im_o,
  input  logic [WIDTH:0]       q_im_i,
  output logic [WIDTH:0]       q_im_o,
  input  logic [WIDTH:0]       lo_im_i,
  output logic [WIDTH:0]       lo_im_o,
  input  logic [WIDTH:0]       rem_i,
  output logic [WIDTH:0]       rem_o,
  input  logic [WIDTH-1:0]     root_i,
  output logic [WIDTH-1:0]     root_o,
  input  logic [2*WIDTH-1:0]   x_i,
  output logic [2*WIDTH-1:0]   x_o
);

  localparam int unsigned W = WIDTH;

  logic             vld_q;
  ctl_t             ctl_q;
  logic [2*W-1:0]   pass_q, d_q, x_q, x_d;
  logic [2*W-2:0]   r_re_q, r_im_q, r_re_d, r_im_d;
  logic [W:0]       q_re_q, q_im_q, lo_re_q, lo_im_q, rem_q, rem_d;
  logic [W-1:0]     root_q, root_d;

  logic [2*W-1:0]   rs_re, rs_im, df_re, df_im;
  logic             ge_re, ge_im;

  // divide bit: shift in next dividend bit, subtract divisor if it fits
  assign rs_re  = {r_re_i, lo_re_i[W]};
  assign rs_im  = {r_im_i, lo_im_i[W]};
  assign ge_re  = rs_re >= d_i;
  assign ge_im  = rs_im >= d_i;
  assign df_re  = rs_re - d_i;
  assign df_im  = rs_im - d_i;
  assign r_re_d = ge_re ? df_re[2*W-2:0] : rs_re[2*W-2:0];
  assign r_im_d = ge_im ? df_im[2*W-2:0] : rs_im[2*W-2:0];

  // square root digit
  if (DO_SQRT) begin : g_sqrt
    logic [W+2:0] rs_sq, trial, df_sq;
    logic         ge_sq;
    assign rs_sq  = {rem_i, x_i[2*W-1 -: 2]};
    assign trial  = {1'b0, root_i, 2'b01};
    assign ge_sq  = rs_sq >= trial;
    assign df_sq  = rs_sq - trial;
    assign rem_d  = ge_sq ? df_sq[W:0] : rs_sq[W:0];
    assign root_d = {root_i[W-2:0], ge_sq};
    assign x_d    = {x_i[2*W-3:0], 2'b00};
  end else begin : g_nosqrt
    assign rem_d  = rem_i;
    assign root_d = root_i;
    assign x_d    = x_i;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q   <= ctl_i;
      pass_q  <= pass_i;
      d_q     <= d_i;
      r_re_q  <= r_re_d;
      r_im_q  <= r_im_d;
      q_re_q  <= {q_re_i[W-1:0], ge_re};
      q_im_q  <= {q_im_i[W-1:0], ge_im};
      lo_re_q <= {lo_re_i[W-1:0], 1'b0};
      lo_im_q <= {lo_im_i[W-1:0], 1'b0};
      rem_q   <= rem_d;
      root_q  <= root_d;
      x_q     <= x_d;
    end
  end

  assign vld_o   = vld_q;
  assign ctl_o   = ctl_q;
  assign pass_o  = pass_q;
  assign d_o     = d_q;
  assign r_re_o  = r_re_q;
  assign r_im_o  = r_im_q;
  assign q_re_o  = q_re_q;
  assign q_im_o  = q_im_q;
  assign lo_re_o = lo_re_q;
  assign lo_im_o = lo_im_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign x_o     = x_q;

endmodule

`default_nettype wire

/* rtl/complex_number_alu.sv */
// Register stages from input word to output word, in order:
// multiply, sum, absolute value, divide setup, WIDTH+1 divide/root steps, output.
// Throughput: one word per cycle while output is ready; one divide bit per stage.
// Each stage advances when the next is empty or moving, so bubbles collapse.
// Reset (async, active low) clears all valid bits; data registers are not reset.
`default_nettype none
`include "complex_number_alu_assert.svh"

module complex_number_alu import cna_pkg::*; #(
  parameter int unsigned WIDTH     = CNA_WIDTH,
  parameter int unsigned FRAC_BITS = CNA_FRAC_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // op[2:0], a_re, a_im, b_re, b_im (WIDTH bits each), zero pad
  input  logic [((CNA_OP_W+4*WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // res_re, res_im (WIDTH bits each), is_equal, status[1:0], zero pad
  output logic [((2*WIDTH+3+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned W     = WIDTH;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned K     = W + 1;       // divide/root steps
  localparam int unsigned NS    = W + 6;       // register stages
  localparam int unsigned OUT_W = ((2*WIDTH+3+7)/8)*8;
  localparam logic [W-1:0]   VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] LIM  = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] LIM2 = {{(W-1){1'b0}}, 1'b1, {W{1'b0}}};

  // saturate a sign/magnitude value to the signed range; returns {sat, value}
  function automatic logic [W:0] fin(input logic neg, input logic [2*W-1:0] m);
    logic         sat;
    logic [W-1:0] v;
    sat = neg ? (m > LIM) : (m >= LIM);
    if (neg) begin
      v = sat ? VMIN : ('0 - m[W-1:0]);
    end else begin
      v = sat ? VMAX : m[W-1:0];
    end
    return {sat, v};
  endfunction

  logic [NS-1:0] vld, en;

  // stage advance chain
  assign en[NS-1] = !vld[NS-1] || m_axis_tready_i;
  for (genvar s = 0; s < NS-1; s++) begin : g_en
    assign en[s] = !vld[s] || en[s+1];
  end
  assign s_axis_tready_o = en[0];

  // ---------------- stage A: products and simple ops ----------------
  op_e              in_op;
  logic signed [W-1:0] in_ar, in_ai, in_br, in_bi;
  logic signed [W:0]   in_sre, in_sim;
  logic [W-1:0]     in_re, in_im;
  logic             in_eq, in_sat_re, in_sat_im;
  status_e          in_st;

  assign in_op = op_e'(s_axis_tdata_i[CNA_OP_W-1:0]);
  assign in_ar = s_axis_tdata_i[CNA_OP_W       +: W];
  assign in_ai = s_axis_tdata_i[CNA_OP_W + W   +: W];
  assign in_br = s_axis_tdata_i[CNA_OP_W + 2*W +: W];
  assign in_bi = s_axis_tdata_i[CNA_OP_W + 3*W +: W];

  always_comb begin
    in_sre    = '0;
    in_sim    = '0;
    in_re     = '0;
    in_im     = '0;
    in_eq     = 1'b0;
    in_sat_re = 1'b0;
    in_sat_im = 1'b0;
    in_st     = ST_OK;
    case (in_op)
      OP_ADD, OP_SUB: begin
        if (in_op == OP_ADD) begin
          in_sre = {in_ar[W-1], in_ar} + {in_br[W-1], in_br};
          in_sim = {in_ai[W-1], in_ai} + {in_bi[W-1], in_bi};
        end else begin
          in_sre = {in_ar[W-1], in_ar} - {in_br[W-1], in_br};
          in_sim = {in_ai[W-1], in_ai} - {in_bi[W-1], in_bi};
        end
        in_sat_re = in_sre[W] ^ in_sre[W-1];
        in_sat_im = in_sim[W] ^ in_sim[W-1];
        in_re = in_sat_re ? (in_sre[W] ? VMIN : VMAX) : in_sre[W-1:0];
        in_im = in_sat_im ? (in_sim[W] ? VMIN : VMAX) : in_sim[W-1:0];
        in_st = (in_sat_re || in_sat_im) ? ST_SAT : ST_OK;
      end
      OP_EQ: begin
        in_eq = (in_ar == in_br) && (in_ai == in_bi);
      end
      default: begin
        in_eq = 1'b0;
      end
    endcase
  end

  logic                  a_vld_q;
  op_e                   a_op_q;
  logic                  a_dz_q, a_eq_q;
  status_e               a_st_q;
  logic [2*W-1:0]        a_pass_q;
  logic signed [2*W-1:0] a_prr_q, a_pii_q, a_pir_q, a_pri_q;
  logic signed [2*W-1:0] a_qar_q, a_qai_q, a_qbr_q, a_qbi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en[0]) begin
      a_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_op_q   <= in_op;
      a_dz_q   <= (in_br == '0) && (in_bi == '0);
      a_eq_q   <= in_eq;
      a_st_q   <= in_st;
      a_pass_q <= {in_im, in_re};
      a_prr_q  <= in_ar * in_br;
      a_pii_q  <= in_ai * in_bi;
      a_pir_q  <= in_ai * in_br;
      a_pri_q  <= in_ar * in_bi;
      a_qar_q  <= in_ar * in_ar;
      a_qai_q  <= in_ai * in_ai;
      a_qbr_q  <= in_br * in_br;
      a_qbi_q  <= in_bi * in_bi;
    end
  end
  assign vld[0] = a_vld_q;

  // ---------------- stage B: cross sums ----------------
  logic [2*W:0]   b_sre_d, b_sim_d;
  logic [2*W:0]   b_sre_q, b_sim_q;
  logic [2*W-1:0] b_d_q, b_mm_q, b_pass_q;
  logic           b_vld_q, b_dz_q, b_eq_q;
  op_e            b_op_q;
  status_e        b_st_q;

  always_comb begin
    if (a_op_q == OP_DIV) begin
      b_sre_d = {a_prr_q[2*W-1], a_prr_q} + {a_pii_q[2*W-1], a_pii_q};
      b_sim_d = {a_pir_q[2*W-1], a_pir_q} - {a_pri_q[2*W-1], a_pri_q};
    end else begin
      b_sre_d = {a_prr_q[2*W-1], a_prr_q} - {a_pii_q[2*W-1], a_pii_q};
      b_sim_d = {a_pir_q[2*W-1], a_pir_q} + {a_pri_q[2*W-1], a_pri_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en[1]) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_sre_q  <= b_sre_d;
      b_sim_q  <= b_sim_d;
      b_d_q    <= a_qbr_q[2*W-1:0] + a_qbi_q[2*W-1:0];
      b_mm_q   <= a_qar_q[2*W-1:0] + a_qai_q[2*W-1:0];
      b_op_q   <= a_op_q;
      b_dz_q   <= a_dz_q;
      b_eq_q   <= a_eq_q;
      b_st_q   <= a_st_q;
      b_pass_q <= a_pass_q;
    end
  end
  assign vld[1] = b_vld_q;

  // ---------------- stage C: sign and magnitude ----------------
  logic [2*W:0]   c_nre, c_nim;
  logic [2*W-1:0] c_mre_q, c_mim_q, c_d_q, c_mm_q, c_pass_q;
  logic           c_vld_q, c_dz_q, c_eq_q, c_neg_re_q, c_neg_im_q;
  op_e            c_op_q;
  status_e        c_st_q;

  assign c_nre = '0 - b_sre_q;
  assign c_nim = '0 - b_sim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en[2]) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_neg_re_q <= b_sre_q[2*W];
      c_neg_im_q <= b_sim_q[2*W];
      c_mre_q    <= b_sre_q[2*W] ? c_nre[2*W-1:0] : b_sre_q[2*W-1:0];
      c_mim_q    <= b_sim_q[2*W] ? c_nim[2*W-1:0] : b_sim_q[2*W-1:0];
      c_d_q      <= b_d_q;
      c_mm_q     <= b_mm_q;
      c_op_q     <= b_op_q;
      c_dz_q     <= b_dz_q;
      c_eq_q     <= b_eq_q;
      c_st_q     <= b_st_q;
      c_pass_q   <= b_pass_q;
    end
  end
  assign vld[2] = c_vld_q;

  // ---------------- stage D: multiply result, divide setup ----------------
  logic [W:0]     d_fre, d_fim;
  logic [2*W-1:0] d_r0re, d_r0im, d_shre, d_shim;
  ctl_t           d_ctl_d, d_ctl_q;
  logic [2*W-1:0] d_pass_d, d_pass_q, d_d_q, d_x_q;
  logic [2*W-2:0] d_rre_q, d_rim_q;
  logic [W:0]     d_lore_q, d_loim_q;
  logic           d_vld_q;

  assign d_fre  = fin(c_neg_re_q, c_mre_q >> F);
  assign d_fim  = fin(c_neg_im_q, c_mim_q >> F);
  assign d_r0re = c_mre_q >> (W + 1 - F);
  assign d_r0im = c_mim_q >> (W + 1 - F);
  assign d_shre = c_mre_q << F;
  assign d_shim = c_mim_q << F;

  always_comb begin
    d_ctl_d.op     = c_op_q;
    d_ctl_d.dz     = c_dz_q;
    d_ctl_d.neg_re = c_neg_re_q;
    d_ctl_d.neg_im = c_neg_im_q;
    d_ctl_d.ovf_re = d_r0re >= c_d_q;
    d_ctl_d.ovf_im = d_r0im >= c_d_q;
    d_ctl_d.eq     = c_eq_q;
    d_ctl_d.st     = c_st_q;
    d_pass_d       = c_pass_q;
    if (c_op_q == OP_MUL) begin
      d_pass_d   = {d_fim[W-1:0], d_fre[W-1:0]};
      d_ctl_d.st = (d_fre[W] || d_fim[W]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en[3]) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d_ctl_q  <= d_ctl_d;
      d_pass_q <= d_pass_d;
      d_d_q    <= c_d_q;
      d_rre_q  <= d_r0re[2*W-2:0];
      d_rim_q  <= d_r0im[2*W-2:0];
      d_lore_q <= d_shre[W:0];
      d_loim_q <= d_shim[W:0];
      d_x_q    <= c_mm_q;
    end
  end
  assign vld[3] = d_vld_q;

  // ---------------- divide / root chain ----------------
  logic           it_vld  [0:K];
  ctl_t           it_ctl  [0:K];
  logic [2*W-1:0] it_pass [0:K];
  logic [2*W-1:0] it_d    [0:K];
  logic [2*W-2:0] it_rre  [0:K];
  logic [W:0]     it_qre  [0:K];
  logic [W:0]     it_lore [0:K];
  logic [2*W-2:0] it_rim  [0:K];
  logic [W:0]     it_qim  [0:K];
  logic [W:0]     it_loim [0:K];
  logic [W:0]     it_rem  [0:K];
  logic [W-1:0]   it_root [0:K];
  logic [2*W-1:0] it_x    [0:K];

  assign it_vld[0]  = d_vld_q;
  assign it_ctl[0]  = d_ctl_q;
  assign it_pass[0] = d_pass_q;
  assign it_d[0]    = d_d_q;
  assign it_rre[0]  = d_rre_q;
  assign it_qre[0]  = '0;
  assign it_lore[0] = d_lore_q;
  assign it_rim[0]  = d_rim_q;
  assign it_qim[0]  = '0;
  assign it_loim[0] = d_loim_q;
  assign it_rem[0]  = '0;
  assign it_root[0] = '0;
  assign it_x[0]    = d_x_q;

  for (genvar k = 0; k < K; k++) begin : g_step
    cna_step #(
      .WIDTH   (W),
      .DO_SQRT (k < W)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[4+k]),
      .vld_i   (it_vld[k]),
      .vld_o   (it_vld[k+1]),
      .ctl_i   (it_ctl[k]),
      .ctl_o   (it_ctl[k+1]),
      .pass_i  (it_pass[k]),
      .pass_o  (it_pass[k+1]),
      .d_i     (it_d[k]),
      .d_o     (it_d[k+1]),
      .r_re_i  (it_rre[k]),
      .r_re_o  (it_rre[k+1]),
      .q_re_i  (it_qre[k]),
      .q_re_o  (it_qre[k+1]),
      .lo_re_i (it_lore[k]),
      .lo_re_o (it_lore[k+1]),
      .r_im_i  (it_rim[k]),
      .r_im_o  (it_rim[k+1]),
      .q_im_i  (it_qim[k]),
      .q_im_o  (it_qim[k+1]),
      .lo_im_i (it_loim[k]),
      .lo_im_o (it_loim[k+1]),
      .rem_i   (it_rem[k]),
      .rem_o   (it_rem[k+1]),
      .root_i  (it_root[k]),
      .root_o  (it_root[k+1]),
      .x_i     (it_x[k]),
      .x_o     (it_x[k+1])
    );
    assign vld[4+k] = it_vld[k+1];
  end

  // ---------------- output stage ----------------
  ctl_t           e_ctl;
  logic [2*W-1:0] e_qre, e_qim;
  logic [W:0]     e_fre, e_fim;
  logic [W-1:0]   e_re, e_im, e_root;
  logic           e_eq;
  status_e        e_st;

  assign e_ctl  = it_ctl[K];
  assign e_root = it_root[K];
  assign e_qre  = {{(W-1){1'b0}}, it_qre[K]} | (e_ctl.ovf_re ? LIM2 : '0);
  assign e_qim  = {{(W-1){1'b0}}, it_qim[K]} | (e_ctl.ovf_im ? LIM2 : '0);
  assign e_fre  = fin(e_ctl.neg_re, e_qre);
  assign e_fim  = fin(e_ctl.neg_im, e_qim);

  always_comb begin
    e_re = it_pass[K][W-1:0];
    e_im = it_pass[K][2*W-1:W];
    e_eq = e_ctl.eq;
    e_st = e_ctl.st;
    case (e_ctl.op)
      OP_DIV: begin
        if (e_ctl.dz) begin
          e_re = '0;
          e_im = '0;
          e_st = ST_DIV0;
        end else begin
          e_re = e_fre[W-1:0];
          e_im = e_fim[W-1:0];
          e_st = (e_fre[W] || e_fim[W]) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        e_re = e_root[W-1] ? VMAX : e_root;
        e_im = '0;
        e_st = e_root[W-1] ? ST_SAT : ST_OK;
      end
      default: begin
        e_eq = e_ctl.eq;
      end
    endcase
  end

  logic         out_vld_q, out_eq_q;
  logic [W-1:0] out_re_q, out_im_q;
  status_e      out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en[NS-1]) begin
      out_vld_q <= it_vld[K];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_re_q <= e_re;
      out_im_q <= e_im;
      out_eq_q <= e_eq;
      out_st_q <= e_st;
    end
  end
  assign vld[NS-1] = out_vld_q;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'({out_st_q, out_eq_q, out_im_q, out_re_q});

  // ---------------- checks ----------------
  `CNA_ASSERT_IMPL(a_div0_zero, out_vld_q && (out_st_q == ST_DIV0), (out_re_q == '0) && (out_im_q == '0), "divide by zero word with nonzero result")
  `CNA_ASSERT_IMPL(a_eq_clean, out_vld_q && out_eq_q, (out_st_q == ST_OK) && (out_re_q == '0) && (out_im_q == '0), "equality word carries arithmetic result")
  `CNA_ASSERT_IMPL(a_bubble_ready, !out_vld_q, s_axis_tready_o, "input stalled with empty output stage")
  `CNA_ASSERT_NEXT(a_stage_move, d_vld_q && en[4], it_vld[1], "word lost entering divide chain")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for complex_number_alu: random and directed complex ops.
// Depends on cna_pkg and the complex_number_alu RTL; prediction is computed locally.
`default_nettype none

module tb_top;
  import cna_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W    = CNA_WIDTH;
  localparam int FB   = CNA_FRAC_BITS;
  localparam int IN_W = ((CNA_OP_W + 4*W + 7)/8)*8;
  localparam int OUT_W = ((2*W + 3 + 7)/8)*8;
  localparam int N_RANDOM = 1300;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [W-1:0] b_im;
    logic [W-1:0] b_re;
    logic [W-1:0] a_im;
    logic [W-1:0] a_re;
    logic [2:0]   op;
  } opnd_t;

  typedef struct packed {
    logic [1:0]   status;
    logic         is_equal;
    logic [W-1:0] res_im;
    logic [W-1:0] res_re;
  } res_t;

  localparam logic signed [127:0] VMAX = (128'sd1 <<< (W-1)) - 1;
  localparam logic signed [127:0] VMIN = -(128'sd1 <<< (W-1));

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [OUT_W-1:0] m_axis_tdata_o;

  complex_number_alu uut (.*);

  opnd_t pending_q[$];
  res_t  expected_q[$];
  int    n_bad, n_results, n_ops[8];
  bit    stim_done, hold_req, hold_done, pause_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // saturate a wide signed value to the result range
  function automatic logic [W-1:0] sat_comp(input logic signed [127:0] v, inout bit sat);
    if (v > VMAX) begin
      sat = 1'b1;
      return VMAX[W-1:0];
    end
    if (v < VMIN) begin
      sat = 1'b1;
      return VMIN[W-1:0];
    end
    return v[W-1:0];
  endfunction

  // truncate toward zero by FB fraction bits
  function automatic logic signed [127:0] trunc_frac(input logic signed [127:0] v);
    logic [127:0] m;
    m = (v < 0) ? -v : v;
    m = m >> FB;
    return (v < 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [127:0] int_sqrt(input logic [127:0] x);
    logic [127:0] r, bitv;
    r = 0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // expected result of one complex operation
  function automatic res_t complex_result(input opnd_t it);
    logic signed [127:0] ar, ai, br, bi, nr, ni, d;
    logic [127:0] mr, mi;
    res_t r;
    bit sat;
    sat = 1'b0;
    r = '0;
    ar = $signed(it.a_re);
    ai = $signed(it.a_im);
    br = $signed(it.b_re);
    bi = $signed(it.b_im);
    case (it.op)
      OP_ADD: begin
        r.res_re = sat_comp(ar + br, sat);
        r.res_im = sat_comp(ai + bi, sat);
      end
      OP_SUB: begin
        r.res_re = sat_comp(ar - br, sat);
        r.res_im = sat_comp(ai - bi, sat);
      end
      OP_MUL: begin
        r.res_re = sat_comp(trunc_frac(ar*br - ai*bi), sat);
        r.res_im = sat_comp(trunc_frac(ai*br + ar*bi), sat);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.status = ST_DIV0;
        end else begin
          d  = br*br + bi*bi;
          nr = ar*br + ai*bi;
          ni = ai*br - ar*bi;
          mr = ((nr < 0) ? -nr : nr) << FB;
          mi = ((ni < 0) ? -ni : ni) << FB;
          mr = mr / d;
          mi = mi / d;
          r.res_re = sat_comp((nr < 0) ? -$signed(mr) : $signed(mr), sat);
          r.res_im = sat_comp((ni < 0) ? -$signed(mi) : $signed(mi), sat);
        end
      end
      OP_MAG: r.res_re = sat_comp($signed(int_sqrt(ar*ar + ai*ai)), sat);
      OP_EQ:  r.is_equal = (ar == br) && (ai == bi);
      default: ;
    endcase
    if (sat) r.status = ST_SAT;
    return r;
  endfunction

  // operand value biased toward extremes and small numbers
  function automatic logic [W-1:0] rand_val();
    case ($urandom_range(0, 9))
      0: return VMAX[W-1:0];
      1: return VMIN[W-1:0];
      2: return '0;
      3: return W'($signed($urandom_range(0, 8)) - 4) <<< FB;
      4, 5: return W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  function automatic opnd_t mk(input logic [2:0] op, input logic [W-1:0] a_re,
                               input logic [W-1:0] a_im, input logic [W-1:0] b_re,
                               input logic [W-1:0] b_im);
    opnd_t it;
    it.op = op; it.a_re = a_re; it.a_im = a_im; it.b_re = b_re; it.b_im = b_im;
    return it;
  endfunction

  // stimulus: directed extremes, then random words with two pressure episodes
  initial begin
    logic [W-1:0] mx, mn, one;
    opnd_t it;
    mx = VMAX[W-1:0];
    mn = VMIN[W-1:0];
    one = W'(1) << FB;
    pending_q.push_back(mk(OP_ADD, mx, mn, mx, mn));
    pending_q.push_back(mk(OP_ADD, one, one, one, -one));
    pending_q.push_back(mk(OP_SUB, mn, mx, mx, mn));
    pending_q.push_back(mk(OP_SUB, '1, '1, '1, 0));
    pending_q.push_back(mk(OP_MUL, mn, mn, mn, mn));
    pending_q.push_back(mk(OP_MUL, mx, mx, mx, mn));
    pending_q.push_back(mk(OP_MUL, one, 3*one, -one, 2*one));
    pending_q.push_back(mk(OP_MUL, -1, 1, 1, 1));
    pending_q.push_back(mk(OP_DIV, one, one, 0, 0));
    pending_q.push_back(mk(OP_DIV, mx, mn, 0, 1));
    pending_q.push_back(mk(OP_DIV, mn, mn, mn, mn));
    pending_q.push_back(mk(OP_DIV, one, 0, 0, one));
    pending_q.push_back(mk(OP_DIV, 7*one, -3*one, 2*one, one));
    pending_q.push_back(mk(OP_DIV, 1, -1, mx, mx));
    pending_q.push_back(mk(OP_MAG, mn, mn, 0, 0));
    pending_q.push_back(mk(OP_MAG, 3*one, 4*one, mx, mn));
    pending_q.push_back(mk(OP_MAG, mx, 0, 0, 0));
    pending_q.push_back(mk(OP_EQ, mx, mn, mx, mn));
    pending_q.push_back(mk(OP_EQ, mx, mn, mx, mn + 1));
    pending_q.push_back(mk(OP_EQ, 0, 0, 0, 0));
    pending_q.push_back(mk(3'd6, mx, mx, mx, mx));
    pending_q.push_back(mk(3'd7, mn, mn, mn, mn));
    for (int i = 0; i < N_RANDOM; i++) begin
      it = mk(3'($urandom_range(0, 7)), rand_val(), rand_val(), rand_val(), rand_val());
      if (it.op == OP_EQ && $urandom_range(0, 1)) begin
        it.b_re = it.a_re;
        if ($urandom_range(0, 2) != 0) it.b_im = it.a_im;
      end
      if (it.op == OP_DIV && $urandom_range(0, 15) == 0) begin
        it.b_re = 0;
        it.b_im = 0;
      end
      pending_q.push_back(it);
      if (i == 400) begin
        // receiver holds off while the sender keeps offering
        wait (pending_q.size() == 0);
        hold_req = 1'b1;
        for (int j = 0; j < 200; j++) pending_q.push_back(
          mk(3'($urandom_range(0, 5)), rand_val(), rand_val(), rand_val(), rand_val()));
        wait (hold_done == 1'b1);
        hold_req = 1'b0;
      end
      if (i == 900) begin
        // sender pauses until the pipeline drains
        wait (pending_q.size() == 0);
        pause_req = 1'b1;
        wait (expected_q.size() == 0);
        pause_req = 1'b0;
      end
    end
    wait (pending_q.size() == 0 && !s_axis_tvalid_i);
    stim_done = 1'b1;
  end

  // driver: per-word random gap, then offer until accepted
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      send_gap        <= 0;
    end else if (s_axis_tvalid_i && !s_axis_tready_o) begin
      // hold the word
    end else if (send_gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      send_gap        <= send_gap - 1;
    end else if (pending_q.size() != 0 && !pause_req) begin
      s_axis_tdata_i  <= IN_W'(pending_q[0]);
      expected_q.push_back(complex_result(pending_q[0]));
      n_ops[pending_q[0].op]++;
      void'(pending_q.pop_front());
      s_axis_tvalid_i <= 1'b1;
      send_gap        <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // long receiver hold-off, counted here
  int hold_cnt;
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES) begin
        hold_done <= 1'b1;
      end
    end
  end

  // monitor: random ready stalls, whole-word compare with a per-field report
  int recv_gap, idle_cycles;
  res_t got, want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_gap        <= 0;
      idle_cycles     <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = res_t'(m_axis_tdata_o[2*W+2:0]);
        n_results++;
        if (expected_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result word %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_axis_tdata_o[OUT_W-1:2*W+3] !== '0) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch #%0d: re %h/%h im %h/%h eq %b/%b st %0d/%0d (exp/act)",
                       n_results, want.res_re, got.res_re, want.res_im, got.res_im,
                       want.is_equal, got.is_equal, want.status, got.status);
          end
        end
      end
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (hold_req && !hold_done) begin
        m_axis_tready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        m_axis_tready_i <= 1'b0;
        recv_gap        <= recv_gap - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (m_axis_tvalid_o && m_axis_tready_i)
          recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end
    end
  end

  // reset, end of run and watchdog
  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        wait (stim_done && expected_q.size() == 0);
        repeat (4*W) @(posedge clk_i);
      end
      wait (idle_cycles >= IDLE_LIMIT);
    join_any
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", expected_q.size());
      $display("FAILED: results differ");
    end else begin
      $display("covered %0d results: add %0d sub %0d mul %0d div %0d mag %0d eq %0d unused %0d",
               n_results, n_ops[0], n_ops[1], n_ops[2], n_ops[3], n_ops[4], n_ops[5],
               n_ops[6] + n_ops[7]);
      $display("with random stalls on both sides, a long output hold-off and a full drain");
      if (n_bad == 0 && expected_q.size() == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("%0d mismatches", n_bad);
        $display("FAILED: results differ");
      end
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/cna_pkg.sv
rtl/cna_step.sv
rtl/complex_number_alu.sv
verif/tb_top.sv
